[hw/rtl/mrfp_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the motor reply frame parser.
// Depends on nothing; the input register, frame core and top level use it by scoped names.
package mrfp_pkg;

    localparam int unsigned KEPT_PAYLOAD_BYTES = 8;
    localparam int unsigned STORE_IDX_W        = $clog2(KEPT_PAYLOAD_BYTES);
    localparam int unsigned COUNT_W            = 9;

    typedef logic [7:0]         byte_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam count_t COUNT_MAX      = '1;
    localparam count_t POS_HEAD       = 9'd0;
    localparam count_t POS_CMD        = 9'd1;
    localparam count_t POS_LEN        = 9'd3;
    localparam count_t POS_HSUM       = 9'd4;
    localparam count_t PAYLOAD_START  = 9'd5;
    localparam count_t MIN_FRAME      = 9'd5;
    localparam count_t FRAME_OVERHEAD = 9'd6;

    localparam byte_t FRAME_HEAD       = 8'h3E;
    localparam byte_t CMD_READ_STATUS1 = 8'h9A;
    localparam byte_t CMD_CLEAR_ERROR  = 8'h9B;
    localparam byte_t CMD_READ_STATUS2 = 8'h9C;
    localparam byte_t CMD_CTRL_FIRST   = 8'hA0;
    localparam byte_t CMD_CTRL_LAST    = 8'hA8;
    localparam byte_t CMD_READ_ANGLE   = 8'h92;
    localparam byte_t CMD_MOTOR_OFF    = 8'h80;
    localparam byte_t CMD_MOTOR_RUN    = 8'h88;
    localparam byte_t CMD_MOTOR_STOP   = 8'h81;

    localparam byte_t STATUS_MIN_LEN = 8'd7;
    localparam byte_t ANGLE_MIN_LEN  = 8'd8;

    typedef enum logic [2:0] {
        STATUS_OK       = 3'd0,
        STATUS_CHECKSUM = 3'd1,
        STATUS_LENGTH   = 3'd2,
        STATUS_HEADER   = 3'd3,
        STATUS_UNKNOWN  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CLASS_STATUS1  = 3'd0,
        CLASS_STATUS2  = 3'd1,
        CLASS_ANGLE    = 3'd2,
        CLASS_NO_DATA  = 3'd3,
        CLASS_UNKNOWN  = 3'd4
    } cmd_class_t;

    typedef struct packed {
        logic signed [7:0]  temperature;
        logic signed [15:0] voltage;
        logic signed [15:0] phase_current;
        logic [7:0]         motor_status;
        logic [7:0]         error_status;
        logic signed [15:0] iq_current;
        logic signed [15:0] speed;
        logic [15:0]        encoder_position;
        logic signed [63:0] shaft_angle;
    } record_t;

    typedef struct packed {
        status_t     status;
        byte_t       command;
        logic [31:0] frame_count;
        record_t     record;
    } result_t;

    // One byte handed from the input register to the frame logic.
    typedef struct packed {
        logic  valid;
        byte_t data_byte;
        logic  last_byte;
    } step_t;

    function automatic cmd_class_t cmd_class(input byte_t cmd);
        cmd_class_t cls;
        cls = CLASS_UNKNOWN;
        if (cmd == CMD_READ_STATUS1 || cmd == CMD_CLEAR_ERROR) begin
            cls = CLASS_STATUS1;
        end
        else if (cmd == CMD_READ_STATUS2 ||
                 (cmd >= CMD_CTRL_FIRST && cmd <= CMD_CTRL_LAST)) begin
            cls = CLASS_STATUS2;
        end
        else if (cmd == CMD_READ_ANGLE) begin
            cls = CLASS_ANGLE;
        end
        else if (cmd == CMD_MOTOR_OFF || cmd == CMD_MOTOR_RUN ||
                 cmd == CMD_MOTOR_STOP) begin
            cls = CLASS_NO_DATA;
        end
        return cls;
    endfunction

endpackage

[hw/rtl/mrfp_byte_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel for received reply bytes with an end-of-frame mark.
// Standalone; no package needed.
interface mrfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[hw/rtl/mrfp_reply_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel for the per-frame status and held motor record.
// Standalone; no package needed.
interface mrfp_reply_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [7:0]         command;
    logic [31:0]        frame_count;
    logic signed [7:0]  temperature;
    logic signed [15:0] voltage;
    logic signed [15:0] phase_current;
    logic [7:0]         motor_status;
    logic [7:0]         error_status;
    logic signed [15:0] iq_current;
    logic signed [15:0] speed;
    logic [15:0]        encoder_position;
    logic signed [63:0] shaft_angle;

    modport source (
        output valid, output status, output command, output frame_count,
        output temperature, output voltage, output phase_current,
        output motor_status, output error_status, output iq_current,
        output speed, output encoder_position, output shaft_angle,
        input ready
    );
    modport sink (
        input valid, input status, input command, input frame_count,
        input temperature, input voltage, input phase_current,
        input motor_status, input error_status, input iq_current,
        input speed, input encoder_position, input shaft_angle,
        output ready
    );
endinterface

[hw/rtl/mrfp_input_reg.sv]
`timescale 1ns / 1ps
// Input register of the parser: holds one accepted byte until the frame logic takes it.
// Depends on mrfp_pkg and mrfp_byte_if.
module mrfp_input_reg (
    input  logic            clk,
    input  logic            rst_n,
    mrfp_byte_if.sink       rx,
    input  logic            out_free,
    output mrfp_pkg::step_t step
);

    logic          valid_reg;
    logic          valid_next;
    mrfp_pkg::byte_t data_reg;
    logic          last_reg;
    logic          fire;
    logic          accept;

    // A final byte advances only when the result register can take its item.
    assign fire     = valid_reg && (!last_reg || out_free);
    assign rx.ready = !valid_reg || fire;
    assign accept   = rx.valid && rx.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= rx.data_byte;
            last_reg <= rx.last_byte;
        end
    end

    assign step.valid     = fire;
    assign step.data_byte = data_reg;
    assign step.last_byte = last_reg;

endmodule

[hw/rtl/mrfp_frame_core.sv]
`timescale 1ns / 1ps
// Frame tracking, frame checks, command decode and the held motor record.
// Depends on mrfp_pkg.
module mrfp_frame_core (
    input  logic              clk,
    input  logic              rst_n,
    input  mrfp_pkg::step_t   step,
    output mrfp_pkg::result_t result
);

    mrfp_pkg::count_t byte_count_reg, byte_count_next;
    mrfp_pkg::byte_t  header_byte_reg, header_byte_next;
    mrfp_pkg::byte_t  command_reg, command_next;
    mrfp_pkg::byte_t  length_reg, length_next;
    mrfp_pkg::byte_t  header_sum_reg, header_sum_next;
    logic             header_sum_ok_reg, header_sum_ok_next;
    mrfp_pkg::byte_t  payload_sum_reg, payload_sum_next;
    mrfp_pkg::byte_t  payload_store_reg [mrfp_pkg::KEPT_PAYLOAD_BYTES];
    mrfp_pkg::record_t record_reg, record_next;
    logic [31:0]      good_frames_reg, good_frames_next;

    mrfp_pkg::count_t pos;
    mrfp_pkg::count_t offset;
    mrfp_pkg::count_t payload_end;
    logic             store_we;
    logic [mrfp_pkg::STORE_IDX_W-1:0] store_idx;
    mrfp_pkg::byte_t  b;
    mrfp_pkg::status_t status;
    logic             frame_pass;
    logic [63:0]      angle;

    assign b           = step.data_byte;
    assign pos         = byte_count_reg;
    assign offset      = pos - mrfp_pkg::PAYLOAD_START;
    assign payload_end = mrfp_pkg::PAYLOAD_START + mrfp_pkg::count_t'(length_reg);
    assign store_idx   = offset[mrfp_pkg::STORE_IDX_W-1:0];

    // Per-byte frame update
    always_comb
    begin
        header_byte_next   = header_byte_reg;
        command_next       = command_reg;
        length_next        = length_reg;
        header_sum_next    = header_sum_reg;
        header_sum_ok_next = header_sum_ok_reg;
        payload_sum_next   = payload_sum_reg;
        store_we           = 1'b0;
        if (pos < mrfp_pkg::POS_HSUM)
        begin
            header_sum_next = header_sum_reg + b;
            if (pos == mrfp_pkg::POS_HEAD)
            begin
                header_byte_next = b;
            end
            else if (pos == mrfp_pkg::POS_CMD)
            begin
                command_next = b;
            end
            else if (pos == mrfp_pkg::POS_LEN)
            begin
                length_next = b;
            end
        end
        else if (pos == mrfp_pkg::POS_HSUM)
        begin
            header_sum_ok_next = (header_sum_reg == b);
        end
        else if (pos < payload_end)
        begin
            payload_sum_next = payload_sum_reg + b;
            store_we = (offset < mrfp_pkg::count_t'(mrfp_pkg::KEPT_PAYLOAD_BYTES));
        end
        byte_count_next = (byte_count_reg == mrfp_pkg::COUNT_MAX) ?
                          byte_count_reg : byte_count_reg + 9'd1;
    end

    // Frame checks on the state as it stands after this byte
    always_comb
    begin
        frame_pass = 1'b0;
        status     = mrfp_pkg::STATUS_OK;
        priority if (byte_count_next < mrfp_pkg::MIN_FRAME)
        begin
            status = mrfp_pkg::STATUS_LENGTH;
        end
        else if (header_byte_next != mrfp_pkg::FRAME_HEAD)
        begin
            status = mrfp_pkg::STATUS_HEADER;
        end
        else if (!header_sum_ok_next)
        begin
            status = mrfp_pkg::STATUS_CHECKSUM;
        end
        else if (length_next != 8'd0)
        begin
            if (byte_count_next !=
                mrfp_pkg::FRAME_OVERHEAD + mrfp_pkg::count_t'(length_next))
            begin
                status = mrfp_pkg::STATUS_LENGTH;
            end
            else if (payload_sum_next != b)
            begin
                status = mrfp_pkg::STATUS_CHECKSUM;
            end
            else
            begin
                frame_pass = 1'b1;
            end
        end
        else if (byte_count_next != mrfp_pkg::MIN_FRAME)
        begin
            status = mrfp_pkg::STATUS_LENGTH;
        end
        else
        begin
            frame_pass = 1'b1;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            angle[8*k +: 8] = payload_store_reg[k];
        end
    end

    // Decode the payload for the command class; the count bumps on any frame pass
    always_comb
    begin
        record_next      = record_reg;
        good_frames_next = good_frames_reg;
        result.status    = status;
        if (frame_pass)
        begin
            good_frames_next = good_frames_reg + 32'd1;
            unique case (mrfp_pkg::cmd_class(command_next))
                mrfp_pkg::CLASS_STATUS1:
                begin
                    if (length_next < mrfp_pkg::STATUS_MIN_LEN)
                    begin
                        result.status = mrfp_pkg::STATUS_LENGTH;
                    end
                    else
                    begin
                        record_next.temperature   = signed'(payload_store_reg[0]);
                        record_next.voltage       =
                            signed'({payload_store_reg[2], payload_store_reg[1]});
                        record_next.phase_current =
                            signed'({payload_store_reg[4], payload_store_reg[3]});
                        record_next.motor_status  = payload_store_reg[5];
                        record_next.error_status  = payload_store_reg[6];
                    end
                end
                mrfp_pkg::CLASS_STATUS2:
                begin
                    if (length_next < mrfp_pkg::STATUS_MIN_LEN)
                    begin
                        result.status = mrfp_pkg::STATUS_LENGTH;
                    end
                    else
                    begin
                        record_next.temperature      = signed'(payload_store_reg[0]);
                        record_next.iq_current       =
                            signed'({payload_store_reg[2], payload_store_reg[1]});
                        record_next.speed            =
                            signed'({payload_store_reg[4], payload_store_reg[3]});
                        record_next.encoder_position =
                            {payload_store_reg[6], payload_store_reg[5]};
                    end
                end
                mrfp_pkg::CLASS_ANGLE:
                begin
                    if (length_next < mrfp_pkg::ANGLE_MIN_LEN)
                    begin
                        result.status = mrfp_pkg::STATUS_LENGTH;
                    end
                    else
                    begin
                        record_next.shaft_angle = signed'(angle);
                    end
                end
                mrfp_pkg::CLASS_NO_DATA:
                begin
                    if (length_next != 8'd0)
                    begin
                        result.status = mrfp_pkg::STATUS_LENGTH;
                    end
                end
                mrfp_pkg::CLASS_UNKNOWN:
                begin
                    result.status = mrfp_pkg::STATUS_UNKNOWN;
                end
                default:
                begin
                    result.status = mrfp_pkg::STATUS_UNKNOWN;
                end
            endcase
        end
        result.command     = command_next;
        result.frame_count = good_frames_next;
        result.record      = record_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= '0;
            header_byte_reg   <= '0;
            command_reg       <= '0;
            length_reg        <= '0;
            header_sum_reg    <= '0;
            header_sum_ok_reg <= 1'b0;
            payload_sum_reg   <= '0;
            record_reg        <= '0;
            good_frames_reg   <= '0;
        end
        else if (step.valid)
        begin
            if (step.last_byte)
            begin
                // End of frame: keep the record and count, clear the frame
                byte_count_reg    <= '0;
                header_byte_reg   <= '0;
                command_reg       <= '0;
                length_reg        <= '0;
                header_sum_reg    <= '0;
                header_sum_ok_reg <= 1'b0;
                payload_sum_reg   <= '0;
                record_reg        <= record_next;
                good_frames_reg   <= good_frames_next;
            end
            else
            begin
                byte_count_reg    <= byte_count_next;
                header_byte_reg   <= header_byte_next;
                command_reg       <= command_next;
                length_reg        <= length_next;
                header_sum_reg    <= header_sum_next;
                header_sum_ok_reg <= header_sum_ok_next;
                payload_sum_reg   <= payload_sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.valid && store_we)
        begin
            payload_store_reg[store_idx] <= b;
        end
    end

endmodule

[hw/rtl/motor_reply_frame_parser.sv]
`timescale 1ns / 1ps
// Top level of the motor reply frame parser: input register, frame logic, result register.
// Depends on mrfp_pkg, mrfp_byte_if, mrfp_reply_if, mrfp_input_reg, mrfp_frame_core.
//
//   channel | direction | handshake    | payload
//   --------+-----------+--------------+---------------------------------------------
//   rx      | in        | valid/ready  | data_byte[7:0], last_byte
//   reply   | out       | valid/ready  | status[2:0], command, frame_count[31:0],
//           |           |              | held record (temperature .. shaft_angle)
//
// One byte per cycle unless a final byte stalls: a byte is held in the input register and
// then folded into the frame state; a final byte loads the result register as it is folded in.
// Unstalled, throughput is one byte per clock, set by the single pass of the frame checks.
// Reset clears frame state, record, frame count and both valid flags; the payload store
// is not cleared. A result left in the result register holds the next final byte in the
// input register, and the input stalls behind it until the result is taken.
module motor_reply_frame_parser (
    input  logic        clk,
    input  logic        rst_n,
    mrfp_byte_if.sink   rx,
    mrfp_reply_if.source reply
);

    mrfp_pkg::step_t   step;
    mrfp_pkg::result_t result;
    mrfp_pkg::result_t result_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;
    logic              load;

    // Result register is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || reply.ready;

    mrfp_input_reg u_input_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .out_free (out_free),
        .step     (step)
    );

    mrfp_frame_core u_frame_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .result (result)
    );

    // Only a final byte produces an item
    assign load = step.valid && step.last_byte;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (reply.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the payload of the item until the sink takes it
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign reply.valid            = out_valid_reg;
    assign reply.status           = result_reg.status;
    assign reply.command          = result_reg.command;
    assign reply.frame_count      = result_reg.frame_count;
    assign reply.temperature      = result_reg.record.temperature;
    assign reply.voltage          = result_reg.record.voltage;
    assign reply.phase_current    = result_reg.record.phase_current;
    assign reply.motor_status     = result_reg.record.motor_status;
    assign reply.error_status     = result_reg.record.error_status;
    assign reply.iq_current       = result_reg.record.iq_current;
    assign reply.speed            = result_reg.record.speed;
    assign reply.encoder_position = result_reg.record.encoder_position;
    assign reply.shaft_angle      = result_reg.record.shaft_angle;

endmodule

[bench/tb_motor_reply_frame_parser.sv]
`timescale 1ns / 1ps
// Self-checking bench for motor_reply_frame_parser: feeds reply frames byte by byte and
// checks every status/record result against a frame predictor kept inside the bench.
// Depends on mrfp_pkg, mrfp_byte_if, mrfp_reply_if and the parser RTL.
module tb_motor_reply_frame_parser;
    import mrfp_pkg::*;

    localparam int unsigned CYCLE_LIMIT      = 200000;
    localparam int unsigned RANDOM_BYTES     = 490;
    localparam int unsigned CALM_START       = 800;   // no idling on either side from here
    localparam int unsigned CALM_END         = 1400;
    localparam int unsigned HOLD_START       = 150;   // receiver backs off from here
    localparam int unsigned HOLD_CYCLES      = 400;
    localparam int unsigned DRAIN_CYCLES     = 16;
    localparam int unsigned LONG_FRAME_BYTES = 515;   // past the 511 byte count ceiling

    typedef enum int {
        FLAW_NONE,
        FLAW_HEAD,
        FLAW_HSUM,
        FLAW_PSUM,
        FLAW_CUT,
        FLAW_SHORT,
        FLAW_PAD,
        FLAW_NOISE,
        FLAW_LONG
    } flaw_t;

    // Tracks the frame the parser is assembling and holds the replies it owes.
    class frame_reply_tracker;
        int unsigned byte_count;
        byte_t       header_byte;
        byte_t       command_byte;
        byte_t       length_byte;
        byte_t       header_sum;
        bit          header_sum_ok;
        byte_t       payload_sum;
        byte_t       payload_kept [KEPT_PAYLOAD_BYTES];
        record_t     held;
        logic [31:0] good_frames;
        result_t     pending_replies [$];
        int unsigned mismatches;

        function new();
            held        = '0;
            good_frames = '0;
            mismatches  = 0;
            foreach (payload_kept[i]) payload_kept[i] = '0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_count    = 0;
            header_byte   = '0;
            command_byte  = '0;
            length_byte   = '0;
            header_sum    = '0;
            header_sum_ok = 1'b0;
            payload_sum   = '0;
        endfunction

        // Decode the little-endian fields of the command class into the held record.
        function status_t decode_payload();
            if (command_byte == CMD_READ_STATUS1 || command_byte == CMD_CLEAR_ERROR)
            begin
                if (length_byte < STATUS_MIN_LEN) return STATUS_LENGTH;
                held.temperature   = payload_kept[0];
                held.voltage       = {payload_kept[2], payload_kept[1]};
                held.phase_current = {payload_kept[4], payload_kept[3]};
                held.motor_status  = payload_kept[5];
                held.error_status  = payload_kept[6];
                return STATUS_OK;
            end
            if (command_byte == CMD_READ_STATUS2 ||
                (command_byte >= CMD_CTRL_FIRST && command_byte <= CMD_CTRL_LAST))
            begin
                if (length_byte < STATUS_MIN_LEN) return STATUS_LENGTH;
                held.temperature      = payload_kept[0];
                held.iq_current       = {payload_kept[2], payload_kept[1]};
                held.speed            = {payload_kept[4], payload_kept[3]};
                held.encoder_position = {payload_kept[6], payload_kept[5]};
                return STATUS_OK;
            end
            if (command_byte == CMD_READ_ANGLE)
            begin
                if (length_byte < ANGLE_MIN_LEN) return STATUS_LENGTH;
                held.shaft_angle = {payload_kept[7], payload_kept[6], payload_kept[5],
                                    payload_kept[4], payload_kept[3], payload_kept[2],
                                    payload_kept[1], payload_kept[0]};
                return STATUS_OK;
            end
            if (command_byte == CMD_MOTOR_OFF || command_byte == CMD_MOTOR_RUN ||
                command_byte == CMD_MOTOR_STOP)
            begin
                return (length_byte != 0) ? STATUS_LENGTH : STATUS_OK;
            end
            return STATUS_UNKNOWN;
        endfunction

        // Run the frame checks in order; bump the count before the command decode.
        function status_t judge_frame(byte_t final_byte);
            if (byte_count < MIN_FRAME) return STATUS_LENGTH;
            if (header_byte != FRAME_HEAD) return STATUS_HEADER;
            if (!header_sum_ok) return STATUS_CHECKSUM;
            if (length_byte != 0)
            begin
                if (byte_count != FRAME_OVERHEAD + length_byte) return STATUS_LENGTH;
                if (payload_sum != final_byte) return STATUS_CHECKSUM;
            end
            else if (byte_count != MIN_FRAME)
            begin
                return STATUS_LENGTH;
            end
            good_frames = good_frames + 1;
            return decode_payload();
        endfunction

        function void note_byte(byte_t rx_byte, logic fin);
            result_t r;
            if (byte_count < POS_HSUM)
            begin
                header_sum += rx_byte;
                if (byte_count == POS_HEAD) header_byte = rx_byte;
                else if (byte_count == POS_CMD) command_byte = rx_byte;
                else if (byte_count == POS_LEN) length_byte = rx_byte;
            end
            else if (byte_count == POS_HSUM)
            begin
                header_sum_ok = (header_sum == rx_byte);
            end
            else if (byte_count < PAYLOAD_START + length_byte)
            begin
                payload_sum += rx_byte;
                if (byte_count - PAYLOAD_START < KEPT_PAYLOAD_BYTES)
                    payload_kept[byte_count - PAYLOAD_START] = rx_byte;
            end
            if (byte_count < COUNT_MAX) byte_count++;
            if (!fin) return;
            r.status      = judge_frame(rx_byte);
            r.command     = command_byte;
            r.frame_count = good_frames;
            r.record      = held;
            pending_replies.push_back(r);
            clear_frame();
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) $display("[%0t] %s", $time, msg);
        endfunction

        function void check_field(string what, logic [63:0] want, logic [63:0] seen);
            if (want !== seen)
                flag($sformatf("reply field %s: expected %h, got %h", what, want, seen));
        endfunction

        function void check_reply(result_t got);
            result_t want;
            if (pending_replies.size() == 0)
            begin
                flag($sformatf("reply with nothing pending: status %0d command %h",
                               got.status, got.command));
                return;
            end
            want = pending_replies.pop_front();
            check_field("status", want.status, got.status);
            check_field("command", want.command, got.command);
            check_field("frame_count", want.frame_count, got.frame_count);
            check_field("temperature", want.record.temperature, got.record.temperature);
            check_field("voltage", want.record.voltage, got.record.voltage);
            check_field("phase_current", want.record.phase_current,
                        got.record.phase_current);
            check_field("motor_status", want.record.motor_status, got.record.motor_status);
            check_field("error_status", want.record.error_status, got.record.error_status);
            check_field("iq_current", want.record.iq_current, got.record.iq_current);
            check_field("speed", want.record.speed, got.record.speed);
            check_field("encoder_position", want.record.encoder_position,
                        got.record.encoder_position);
            check_field("shaft_angle", want.record.shaft_angle, got.record.shaft_angle);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    int unsigned cycle_cnt  = 0;
    int unsigned bytes_sent = 0;
    byte_t       frame_q [$];

    frame_reply_tracker tracker = new();

    mrfp_byte_if  rx_ch ();
    mrfp_reply_if reply_ch ();

    motor_reply_frame_parser DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .reply (reply_ch)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Count cycles and stop a hung run.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic bit in_calm_window();
        return cycle_cnt >= CALM_START && cycle_cnt < CALM_END;
    endfunction

    // Offer one byte; idle first at random, then hold it until the parser takes it.
    task automatic send_item(input byte_t rx_byte, input logic fin);
        while (!in_calm_window() && $urandom_range(99) < 33)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid     <= 1'b1;
        rx_ch.data_byte <= rx_byte;
        rx_ch.last_byte <= fin;
        @(posedge clk);
        while (!rx_ch.ready) @(posedge clk);
        tracker.note_byte(rx_byte, fin);
        bytes_sent++;
    endtask

    // Build one reply frame, damage it as the flaw asks, and send it with the end mark
    // on its last byte. A fill of zero or more sets every payload byte to that value.
    task automatic send_frame(input byte_t cmd, input int unsigned len, input flaw_t flaw,
                              input int fill = -1);
        byte_t       hsum;
        byte_t       psum;
        byte_t       pb;
        int unsigned keep;
        int unsigned i;
        frame_q.delete();
        if (flaw == FLAW_NOISE)
        begin
            repeat ($urandom_range(1, 12)) frame_q.push_back(byte_t'($urandom));
        end
        else
        begin
            frame_q.push_back(flaw == FLAW_HEAD ?
                              FRAME_HEAD ^ byte_t'($urandom_range(1, 255)) : FRAME_HEAD);
            frame_q.push_back(cmd);
            frame_q.push_back(byte_t'($urandom));
            frame_q.push_back(byte_t'(len));
            hsum = frame_q[0] + frame_q[1] + frame_q[2] + frame_q[3];
            if (flaw == FLAW_HSUM) hsum ^= byte_t'($urandom_range(1, 255));
            frame_q.push_back(hsum);
            psum = '0;
            for (i = 0; i < len; i++)
            begin
                pb = (fill < 0) ? byte_t'($urandom) : byte_t'(fill);
                psum += pb;
                frame_q.push_back(pb);
            end
            if (len != 0)
            begin
                if (flaw == FLAW_PSUM) psum ^= byte_t'($urandom_range(1, 255));
                frame_q.push_back(psum);
            end
            // Cut early, cut to a stub below the minimum, or run on past the end.
            if (flaw == FLAW_CUT && frame_q.size() > 1)
            begin
                keep = $urandom_range(1, frame_q.size() - 1);
                while (frame_q.size() > keep) void'(frame_q.pop_back());
            end
            if (flaw == FLAW_SHORT)
            begin
                keep = $urandom_range(1, 4);
                while (frame_q.size() > keep) void'(frame_q.pop_back());
            end
            if (flaw == FLAW_PAD)
                repeat ($urandom_range(1, 3)) frame_q.push_back(byte_t'($urandom));
            if (flaw == FLAW_LONG)
                while (frame_q.size() < LONG_FRAME_BYTES) frame_q.push_back(byte_t'($urandom));
        end
        for (i = 0; i < frame_q.size(); i++)
            send_item(frame_q[i], i == frame_q.size() - 1);
    endtask

    // Receiver: check each taken reply, then pick ready for the next cycle. Hold off
    // for a long stretch once so the parser backs up and stalls the byte stream.
    initial
    begin : reply_sink
        int unsigned hold_left;
        result_t     got;
        hold_left      = 0;
        reply_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (reply_ch.valid && reply_ch.ready)
            begin
                got.status                  = status_t'(reply_ch.status);
                got.command                 = reply_ch.command;
                got.frame_count             = reply_ch.frame_count;
                got.record.temperature      = reply_ch.temperature;
                got.record.voltage          = reply_ch.voltage;
                got.record.phase_current    = reply_ch.phase_current;
                got.record.motor_status     = reply_ch.motor_status;
                got.record.error_status     = reply_ch.error_status;
                got.record.iq_current       = reply_ch.iq_current;
                got.record.speed            = reply_ch.speed;
                got.record.encoder_position = reply_ch.encoder_position;
                got.record.shaft_angle      = reply_ch.shaft_angle;
                tracker.check_reply(got);
            end
            if (cycle_cnt == HOLD_START) hold_left = HOLD_CYCLES;
            if (hold_left > 0)
            begin
                hold_left--;
                reply_ch.ready <= 1'b0;
            end
            else if (in_calm_window())
            begin
                reply_ch.ready <= 1'b1;
            end
            else
            begin
                reply_ch.ready <= ($urandom_range(99) >= 33);
            end
        end
    end

    initial
    begin : byte_source
        int unsigned random_start;
        int unsigned sel;
        int unsigned len;
        byte_t       cmd;
        flaw_t       flaw;
        rst_n           = 1'b0;
        rx_ch.valid     = 1'b0;
        rx_ch.data_byte = '0;
        rx_ch.last_byte = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every command class with extreme payloads, the count-then-fail
        // cases, each frame check failing, stubs and a frame past the count ceiling.
        send_frame(CMD_MOTOR_OFF, 0, FLAW_NONE);
        send_frame(CMD_MOTOR_RUN, 0, FLAW_NONE);
        send_frame(CMD_MOTOR_STOP, 0, FLAW_NONE);
        send_frame(CMD_READ_STATUS1, STATUS_MIN_LEN, FLAW_NONE, 8'hFF);
        send_frame(CMD_CLEAR_ERROR, STATUS_MIN_LEN, FLAW_NONE, 8'h80);
        send_frame(CMD_READ_STATUS2, STATUS_MIN_LEN, FLAW_NONE, 8'h7F);
        send_frame(CMD_CTRL_FIRST, STATUS_MIN_LEN, FLAW_NONE, 8'h00);
        send_frame(CMD_CTRL_LAST, 9, FLAW_NONE);
        send_frame(CMD_READ_ANGLE, ANGLE_MIN_LEN, FLAW_NONE, 8'hFF);
        send_frame(CMD_READ_ANGLE, ANGLE_MIN_LEN, FLAW_NONE, 8'h80);
        send_frame(CMD_READ_ANGLE, STATUS_MIN_LEN, FLAW_NONE);
        send_frame(CMD_READ_STATUS1, 3, FLAW_NONE);
        send_frame(CMD_MOTOR_STOP, 2, FLAW_NONE);
        send_frame(8'hFF, 0, FLAW_NONE);
        send_frame(CMD_CTRL_LAST + 8'd1, 4, FLAW_NONE);
        send_frame(8'h00, 0, FLAW_NONE);
        send_frame(CMD_CTRL_FIRST + 8'd5, 20, FLAW_NONE);
        send_frame(CMD_READ_STATUS2, STATUS_MIN_LEN, FLAW_HEAD);
        send_frame(CMD_READ_STATUS2, STATUS_MIN_LEN, FLAW_HSUM);
        send_frame(CMD_READ_STATUS2, STATUS_MIN_LEN, FLAW_PSUM);
        send_frame(CMD_MOTOR_OFF, 0, FLAW_SHORT);
        send_frame(CMD_READ_ANGLE, ANGLE_MIN_LEN, FLAW_PAD);
        send_frame(CMD_READ_STATUS1, 255, FLAW_LONG);

        // Random: mostly well-formed frames with random content, the rest damaged.
        random_start = bytes_sent;
        while (bytes_sent < random_start + RANDOM_BYTES)
        begin
            sel = $urandom_range(99);
            if (sel < 20)
            begin
                cmd = $urandom_range(1) ? CMD_READ_STATUS1 : CMD_CLEAR_ERROR;
                len = STATUS_MIN_LEN;
            end
            else if (sel < 45)
            begin
                cmd = ($urandom_range(9) == 0) ? CMD_READ_STATUS2 :
                      CMD_CTRL_FIRST + byte_t'($urandom_range(CMD_CTRL_LAST - CMD_CTRL_FIRST));
                len = STATUS_MIN_LEN;
            end
            else if (sel < 60)
            begin
                cmd = CMD_READ_ANGLE;
                len = ANGLE_MIN_LEN;
            end
            else if (sel < 78)
            begin
                case ($urandom_range(2))
                    0:       cmd = CMD_MOTOR_OFF;
                    1:       cmd = CMD_MOTOR_RUN;
                    default: cmd = CMD_MOTOR_STOP;
                endcase
                len = 0;
            end
            else
            begin
                cmd = byte_t'($urandom);
                len = $urandom_range(0, 8);
            end
            // Vary the length now and then, rarely well past the kept payload.
            sel = $urandom_range(99);
            if (sel < 12) len = $urandom_range(0, 12);
            else if (sel < 15) len = $urandom_range(16, 80);

            sel = $urandom_range(99);
            if (sel < 70) flaw = FLAW_NONE;
            else if (sel < 75) flaw = FLAW_HEAD;
            else if (sel < 80) flaw = FLAW_HSUM;
            else if (sel < 85) flaw = FLAW_PSUM;
            else if (sel < 90) flaw = FLAW_CUT;
            else if (sel < 94) flaw = FLAW_PAD;
            else if (sel < 97) flaw = FLAW_SHORT;
            else flaw = FLAW_NOISE;
            send_frame(cmd, len, flaw);
        end
        rx_ch.valid <= 1'b0;

        // Drain: wait for every owed reply, then keep watching for strays before the verdict.
        while (tracker.pending_replies.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
